// ===== rtl/core/lfvc_pkg.sv =====
// Shared constants, register codes and arithmetic helpers of the line following controller.
`timescale 1ns / 1ps
`default_nettype none

package lfvc_pkg;

  localparam int CORDIC_STEPS = 24;

  localparam logic signed [16:0] PI_Q12     = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
  localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;

  typedef enum logic [2:0] {
    CFG_FORWARD_LIMIT     = 3'd0,
    CFG_LATERAL_LIMIT     = 3'd1,
    CFG_TURN_LIMIT        = 3'd2,
    CFG_SLOWDOWN_DISTANCE = 3'd3,
    CFG_STEER_GAIN        = 3'd4,
    CFG_REVERSE_ALLOWED   = 3'd5
  } cfg_reg_t;

  // atan(2^-i) in units of 2^-24 rad
  function automatic logic signed [27:0] atan_q24(input int i);
    case (i)
      0:       return 28'sd13176795;
      1:       return 28'sd7778716;
      2:       return 28'sd4110060;
      3:       return 28'sd2086331;
      4:       return 28'sd1047214;
      5:       return 28'sd524117;
      6:       return 28'sd262123;
      7:       return 28'sd131069;
      8:       return 28'sd65536;
      9:       return 28'sd32768;
      10:      return 28'sd16384;
      11:      return 28'sd8192;
      12:      return 28'sd4096;
      13:      return 28'sd2048;
      14:      return 28'sd1024;
      15:      return 28'sd512;
      16:      return 28'sd256;
      17:      return 28'sd128;
      18:      return 28'sd64;
      19:      return 28'sd32;
      20:      return 28'sd16;
      21:      return 28'sd8;
      22:      return 28'sd4;
      default: return 28'sd2;
    endcase
  endfunction

  // divide by 2^s, rounding half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lfvc_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lfvc_isqrt #(
  parameter int W = 64
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [W-1:0]     in_v,
  output logic      [W/2-1:0]   root
);

  localparam int N = W / 2;

  logic [W-1:0] rem_r [N];
  logic [W-1:0] res_r [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    localparam logic [W-1:0] BITW = W'(1) << (W - 2 - 2 * i);
    logic [W-1:0] rem_in, res_in, rem_nxt, res_nxt;

    if (i == 0) begin : g_first
      assign rem_in = in_v;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign res_in = res_r[i-1];
    end

    always_comb begin
      if (rem_in >= res_in + BITW) begin
        rem_nxt = rem_in - (res_in + BITW);
        res_nxt = (res_in >> 1) + BITW;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        res_r[i] <= res_nxt;
      end
    end
  end

  assign root = res_r[N-1][N-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/lfvc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lfvc_div #(
  parameter int NW = 60,
  parameter int DW = 32,
  parameter int QW = 29
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [NW-1:0]  num,
  input  wire logic [DW-1:0]  den,
  output logic      [QW-1:0]  quo
);

  localparam int T = NW + DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int J = QW - 1 - k;
    logic [NW-1:0] rem_in, rem_nxt;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in, q_nxt;
    logic [T-1:0]  trial;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    always_comb begin
      trial   = T'(den_in) << J;
      rem_nxt = rem_in;
      q_nxt   = q_in;
      if (T'(rem_in) >= trial) begin
        rem_nxt  = NW'(T'(rem_in) - trial);
        q_nxt[J] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

`default_nettype wire

// ===== rtl/core/line_following_velocity_controller.sv =====
// Top level of the line following velocity controller: config, datapath pipeline, output.
//
// Each input transaction carries a robot pose and a line segment with a wanted speed; each
// produces exactly one output transaction with forward, lateral and turn commands plus a
// flag for a segment of zero length (all commands then zero).
// Channels use valid/stall; a transaction moves on an edge with valid high and stall low.
// Throughput: one transaction per cycle while the output is not stalled. The longest path
// is the segment-length square root (32 stages, one root bit each) followed by the
// unit-direction divider (29 stages, one quotient bit each) and the cross-track products.
// The heading CORDIC (24 stages) and the slowdown path (root, then a 16-stage divider)
// run alongside and are delayed to line up.
// The whole pipeline advances together; when a result waits at the output under stall,
// every stage holds and in_stall is raised, so nothing is lost or repeated.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write only while
// the pipeline is empty. Unknown indexes are ignored.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults:
// forward limit 1.0, lateral limit 0.5, turn limit 1.0, slowdown off, gain 1.0, no reverse.
`timescale 1ns / 1ps
`default_nettype none

module line_following_velocity_controller (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_robot_x,
  input  wire logic signed [31:0] in_robot_y,
  input  wire logic signed [14:0] in_robot_heading,
  input  wire logic signed [31:0] in_start_x,
  input  wire logic signed [31:0] in_start_y,
  input  wire logic signed [31:0] in_end_x,
  input  wire logic signed [31:0] in_end_y,
  input  wire logic signed [15:0] in_wanted_speed,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_forward_speed,
  output logic signed [15:0]      out_lateral_speed,
  output logic signed [15:0]      out_turn_rate,
  output logic                    out_degenerate_line,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);

  localparam int LAT    = 70;
  localparam int SIDE_N = 67;
  localparam int LT_N   = 16;
  localparam int FWD_N  = 14;
  localparam int TRN_N  = 38;
  localparam int CS     = lfvc_pkg::CORDIC_STEPS;

  typedef struct packed {
    logic [30:0]        nax;
    logic [30:0]        nay;
    logic               sgx;
    logic               sgy;
    logic signed [32:0] relx;
    logic signed [32:0] rely;
    logic signed [15:0] v;
    logic               sc;
    logic               deg;
    logic signed [14:0] hd;
  } side_t;

  // configuration
  logic [14:0] fwd_lim_r, lat_lim_r, trn_lim_r;
  logic [30:0] slow_r;
  logic [15:0] gain_r;
  logic        rev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_lim_r <= 15'd4096;
      lat_lim_r <= 15'd2048;
      trn_lim_r <= 15'd4096;
      slow_r    <= '0;
      gain_r    <= 16'd256;
      rev_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lfvc_pkg::CFG_FORWARD_LIMIT:     fwd_lim_r <= cfg_data[14:0];
        lfvc_pkg::CFG_LATERAL_LIMIT:     lat_lim_r <= cfg_data[14:0];
        lfvc_pkg::CFG_TURN_LIMIT:        trn_lim_r <= cfg_data[14:0];
        lfvc_pkg::CFG_SLOWDOWN_DISTANCE: slow_r    <= cfg_data;
        lfvc_pkg::CFG_STEER_GAIN:        gain_r    <= cfg_data[15:0];
        lfvc_pkg::CFG_REVERSE_ALLOWED:   rev_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [LAT-1:0] vld_r;
  logic           en;

  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage 0: capture
  logic signed [31:0] rx0_r, ry0_r, sx0_r, sy0_r, ex0_r, ey0_r;
  logic signed [14:0] hd0_r;
  logic signed [15:0] want0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rx0_r   <= in_robot_x;
      ry0_r   <= in_robot_y;
      hd0_r   <= in_robot_heading;
      sx0_r   <= in_start_x;
      sy0_r   <= in_start_y;
      ex0_r   <= in_end_x;
      ey0_r   <= in_end_y;
      want0_r <= in_wanted_speed;
    end
  end

  // stage 1: differences and magnitudes
  logic signed [32:0] dx, dy, ddx, ddy, relx, rely;
  logic [32:0]        adx, ady, addx, addy;
  logic signed [15:0] v1;
  logic [32:0]        ax1_r, ay1_r;
  logic               sgx1_r, sgy1_r, sc1_r, deg1_r;
  logic signed [32:0] relx1_r, rely1_r;
  logic [30:0]        mdx1_r, mdy1_r;
  logic signed [15:0] v1_r;
  logic signed [14:0] hd1_r;

  always_comb begin
    dx   = {ex0_r[31], ex0_r} - {sx0_r[31], sx0_r};
    dy   = {ey0_r[31], ey0_r} - {sy0_r[31], sy0_r};
    ddx  = {ex0_r[31], ex0_r} - {rx0_r[31], rx0_r};
    ddy  = {ey0_r[31], ey0_r} - {ry0_r[31], ry0_r};
    relx = {rx0_r[31], rx0_r} - {sx0_r[31], sx0_r};
    rely = {ry0_r[31], ry0_r} - {sy0_r[31], sy0_r};
    adx  = dx[32] ? 33'(-dx) : 33'(dx);
    ady  = dy[32] ? 33'(-dy) : 33'(dy);
    addx = ddx[32] ? 33'(-ddx) : 33'(ddx);
    addy = ddy[32] ? 33'(-ddy) : 33'(ddy);
    if (want0_r < $signed({2'b00, fwd_lim_r})) begin
      v1 = want0_r;
    end else begin
      v1 = $signed({1'b0, fwd_lim_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r   <= adx;
      ay1_r   <= ady;
      sgx1_r  <= dx[32];
      sgy1_r  <= dy[32];
      relx1_r <= relx;
      rely1_r <= rely;
      mdx1_r  <= addx[30:0];
      mdy1_r  <= addy[30:0];
      v1_r    <= v1;
      // far from the end: no slowdown scaling
      sc1_r   <= (slow_r != '0) && (addx[32:31] == 2'b00) && (addy[32:31] == 2'b00);
      deg1_r  <= (dx == '0) && (dy == '0);
      hd1_r   <= hd0_r;
    end
  end

  // stage 2: normalise so that max(|dx|,|dy|) lies in [2^30, 2^31)
  logic [32:0]        mx;
  logic [5:0]         msb;
  logic [30:0]        nax, nay;
  side_t              side_nxt;
  side_t              side_r [SIDE_N];
  logic [30:0]        mdx2_r, mdy2_r;
  logic signed [31:0] nx2_r, ny2_r;

  always_comb begin
    mx  = (ax1_r > ay1_r) ? ax1_r : ay1_r;
    msb = '0;
    for (int k = 0; k < 33; k++) begin
      if (mx[k]) msb = 6'(k);
    end
    if (msb > 6'd30) begin
      nax = 31'(ax1_r >> (msb - 6'd30));
      nay = 31'(ay1_r >> (msb - 6'd30));
    end else begin
      nax = 31'(ax1_r << (6'd30 - msb));
      nay = 31'(ay1_r << (6'd30 - msb));
    end
    side_nxt.nax  = nax;
    side_nxt.nay  = nay;
    side_nxt.sgx  = sgx1_r;
    side_nxt.sgy  = sgy1_r;
    side_nxt.relx = relx1_r;
    side_nxt.rely = rely1_r;
    side_nxt.v    = v1_r;
    side_nxt.sc   = sc1_r;
    side_nxt.deg  = deg1_r;
    side_nxt.hd   = hd1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < SIDE_N; k++) side_r[k] <= side_r[k-1];
      mdx2_r <= mdx1_r;
      mdy2_r <= mdy1_r;
      nx2_r  <= sgx1_r ? -$signed({1'b0, nax}) : $signed({1'b0, nax});
      ny2_r  <= sgy1_r ? -$signed({1'b0, nay}) : $signed({1'b0, nay});
    end
  end

  // stage 3: squares; CORDIC quadrant fold
  logic [61:0]        sqa3_r, sqb3_r, dsx3_r, dsy3_r;
  logic signed [35:0] cx3_r, cy3_r;
  logic signed [27:0] cz3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqa3_r <= side_r[0].nax * side_r[0].nax;
      sqb3_r <= side_r[0].nay * side_r[0].nay;
      dsx3_r <= mdx2_r * mdx2_r;
      dsy3_r <= mdy2_r * mdy2_r;
      if (nx2_r < 0) begin
        if (ny2_r >= 0) begin
          cx3_r <= 36'(ny2_r);
          cy3_r <= -36'(nx2_r);
          cz3_r <= lfvc_pkg::HALF_PI_Q24;
        end else begin
          cx3_r <= -36'(ny2_r);
          cy3_r <= 36'(nx2_r);
          cz3_r <= -lfvc_pkg::HALF_PI_Q24;
        end
      end else begin
        cx3_r <= 36'(nx2_r);
        cy3_r <= 36'(ny2_r);
        cz3_r <= '0;
      end
    end
  end

  // stage 4: sums of squares
  logic [63:0] lsum4_r, dsum4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lsum4_r <= 64'(sqa3_r) + 64'(sqb3_r);
      dsum4_r <= 64'(dsx3_r) + 64'(dsy3_r);
    end
  end

  // stages 5..36: segment length and distance to end
  logic [31:0] len36, dist36;

  lfvc_isqrt #(.W(64)) u_len (
    .clk  (clk),
    .en   (en),
    .in_v (lsum4_r),
    .root (len36)
  );

  lfvc_isqrt #(.W(64)) u_dist (
    .clk  (clk),
    .en   (en),
    .in_v (dsum4_r),
    .root (dist36)
  );

  // stages 37..65: unit direction, rounded
  logic [59:0] numx, numy;
  logic [28:0] qx65, qy65;

  assign numx = 60'({side_r[34].nax, 28'd0}) + 60'(len36[31:1]);
  assign numy = 60'({side_r[34].nay, 28'd0}) + 60'(len36[31:1]);

  lfvc_div #(.NW(60), .DW(32), .QW(29)) u_divx (
    .clk (clk),
    .en  (en),
    .num (numx),
    .den (len36),
    .quo (qx65)
  );

  lfvc_div #(.NW(60), .DW(32), .QW(29)) u_divy (
    .clk (clk),
    .en  (en),
    .num (numy),
    .den (len36),
    .quo (qy65)
  );

  // stage 66..68: cross-track error and lateral product
  logic signed [29:0] ux66, uy66;
  logic signed [62:0] pa66_r, pb66_r;
  logic signed [63:0] e67;
  logic signed [35:0] e67_r;
  logic signed [52:0] p68_r;

  always_comb begin
    ux66 = side_r[63].sgx ? -$signed({1'b0, qx65}) : $signed({1'b0, qx65});
    uy66 = side_r[63].sgy ? -$signed({1'b0, qy65}) : $signed({1'b0, qy65});
    e67  = lfvc_pkg::rnd_shr(64'(pa66_r) - 64'(pb66_r), 28);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa66_r <= ux66 * side_r[63].rely;
      pb66_r <= uy66 * side_r[63].relx;
      e67_r  <= 36'(e67);
      p68_r  <= $signed({1'b0, gain_r}) * e67_r;
    end
  end

  // CORDIC vectoring, stages 4..27
  logic signed [35:0] cx_r [CS];
  logic signed [35:0] cy_r [CS];
  logic signed [27:0] cz_r [CS];

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [35:0] xin, yin, xs, ys;
    logic signed [27:0] zin;

    if (i == 0) begin : g_first
      assign xin = cx3_r;
      assign yin = cy3_r;
      assign zin = cz3_r;
    end else begin : g_next
      assign xin = cx_r[i-1];
      assign yin = cy_r[i-1];
      assign zin = cz_r[i-1];
    end

    assign xs = xin >>> i;
    assign ys = yin >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (yin >= 0) begin
          cx_r[i] <= xin + ys;
          cy_r[i] <= yin - xs;
          cz_r[i] <= zin + lfvc_pkg::atan_q24(i);
        end else begin
          cx_r[i] <= xin - ys;
          cy_r[i] <= yin + xs;
          cz_r[i] <= zin - lfvc_pkg::atan_q24(i);
        end
      end
    end
  end

  // stages 28..30: heading error, wrap, turn command
  logic signed [15:0] lh28;
  logic signed [16:0] err28;
  logic signed [15:0] err28_r;
  logic signed [32:0] prod29_r;
  logic signed [63:0] om30;
  logic signed [15:0] turn30;
  logic signed [15:0] turn30_r;
  logic signed [15:0] turn_dl_r [TRN_N];

  always_comb begin
    lh28  = 16'(lfvc_pkg::rnd_shr(64'(cz_r[CS-1]), 12));
    err28 = 17'(lh28) - 17'(side_r[25].hd);
    if (err28 > lfvc_pkg::PI_Q12) begin
      err28 = err28 - lfvc_pkg::TWO_PI_Q12;
    end else if (err28 <= -lfvc_pkg::PI_Q12) begin
      err28 = err28 + lfvc_pkg::TWO_PI_Q12;
    end
    om30 = lfvc_pkg::rnd_shr(64'(prod29_r), 8);
    if (om30 > 64'($signed({1'b0, trn_lim_r}))) begin
      turn30 = $signed({1'b0, trn_lim_r});
    end else if (om30 < -64'($signed({1'b0, trn_lim_r}))) begin
      turn30 = -$signed({1'b0, trn_lim_r});
    end else begin
      turn30 = 16'(om30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err28_r  <= 16'(err28);
      prod29_r <= err28_r * $signed({1'b0, gain_r});
      turn30_r <= turn30;
      turn_dl_r[0] <= turn30_r;
      for (int k = 1; k < TRN_N; k++) turn_dl_r[k] <= turn_dl_r[k-1];
    end
  end

  // forward path: stage 37 product, stages 38..53 divide, stage 54 clamp
  logic [15:0]        mv36;
  logic [47:0]        prod37_r;
  logic               lt37_r;
  logic [LT_N-1:0]    lt_dl_r;
  logic [15:0]        q53;
  logic signed [16:0] vs54, lo54, hi54;
  logic signed [15:0] fwd54_r;
  logic signed [15:0] fwd_dl_r [FWD_N];

  assign mv36 = side_r[34].v[15] ? 16'(-side_r[34].v) : 16'(side_r[34].v);

  lfvc_div #(.NW(48), .DW(31), .QW(16)) u_divf (
    .clk (clk),
    .en  (en),
    .num (prod37_r),
    .den (slow_r),
    .quo (q53)
  );

  always_comb begin
    vs54 = 17'(side_r[51].v);
    if (side_r[51].sc && lt_dl_r[LT_N-1]) begin
      vs54 = side_r[51].v[15] ? -$signed({1'b0, q53}) : $signed({1'b0, q53});
    end
    hi54 = $signed({2'b00, fwd_lim_r});
    lo54 = rev_r ? -hi54 : 17'sd0;
    if (vs54 < lo54) begin
      vs54 = lo54;
    end else if (vs54 > hi54) begin
      vs54 = hi54;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod37_r <= mv36 * dist36;
      lt37_r   <= dist36 < {1'b0, slow_r};
      lt_dl_r  <= {lt_dl_r[LT_N-2:0], lt37_r};
      fwd54_r  <= 16'(vs54);
      fwd_dl_r[0] <= fwd54_r;
      for (int k = 1; k < FWD_N; k++) fwd_dl_r[k] <= fwd_dl_r[k-1];
    end
  end

  // stage 69: lateral clamp and output register
  logic signed [63:0] lat69;
  logic signed [15:0] latc69;
  logic signed [15:0] out_fwd_r, out_lat_r, out_turn_r;
  logic               out_deg_r;

  always_comb begin
    lat69 = lfvc_pkg::rnd_shr(-64'(p68_r), 12);
    if (lat69 > 64'($signed({1'b0, lat_lim_r}))) begin
      latc69 = $signed({1'b0, lat_lim_r});
    end else if (lat69 < -64'($signed({1'b0, lat_lim_r}))) begin
      latc69 = -$signed({1'b0, lat_lim_r});
    end else begin
      latc69 = 16'(lat69);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_deg_r <= side_r[SIDE_N-1].deg;
      if (side_r[SIDE_N-1].deg) begin
        out_fwd_r  <= '0;
        out_lat_r  <= '0;
        out_turn_r <= '0;
      end else begin
        out_fwd_r  <= fwd_dl_r[FWD_N-1];
        out_lat_r  <= latc69;
        out_turn_r <= turn_dl_r[TRN_N-1];
      end
    end
  end

  assign out_valid           = vld_r[LAT-1];
  assign out_forward_speed   = out_fwd_r;
  assign out_lateral_speed   = out_lat_r;
  assign out_turn_rate       = out_turn_r;
  assign out_degenerate_line = out_deg_r;

  // a zero-length segment gives zero commands
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate_line |->
      out_forward_speed == '0 && out_lateral_speed == '0 && out_turn_rate == '0)
    else $error("degenerate segment with non-zero command");

  a_lat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lateral_speed <= $signed({1'b0, lat_lim_r}) &&
                  out_lateral_speed >= -$signed({1'b0, lat_lim_r}))
    else $error("lateral command beyond limit");

  a_turn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_turn_rate <= $signed({1'b0, trn_lim_r}) &&
                  out_turn_rate >= -$signed({1'b0, trn_lim_r}))
    else $error("turn command beyond limit");

  a_fwd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_forward_speed <= $signed({1'b0, fwd_lim_r}))
    else $error("forward command beyond limit");

  // a held result freezes the whole pipe
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_forward_speed) &&
      $stable(out_lateral_speed) && $stable(out_turn_rate) && $stable(vld_r))
    else $error("pipeline moved under output stall");

endmodule

`default_nettype wire

// ===== sim/lfvc_checker.sv =====
// Checker for the line following controller: predicts each command set and compares it.
`timescale 1ns / 1ps

module lfvc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_robot_x,
  input  logic signed [31:0] in_robot_y,
  input  logic signed [14:0] in_robot_heading,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [15:0] in_wanted_speed,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_forward_speed,
  input  logic signed [15:0] out_lateral_speed,
  input  logic signed [15:0] out_turn_rate,
  input  logic               out_degenerate_line,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);

  typedef struct packed {
    logic signed [15:0] fwd;
    logic signed [15:0] lat;
    logic signed [15:0] turn;
    logic               degen;
  } command_t;

  command_t command_q[$];

  logic [14:0] fwd_lim, lat_lim, turn_lim;
  logic [30:0] slow_dist;
  logic [15:0] gain;
  logic        rev_en;

  localparam longint ATAN_Q24 [24] = '{13176795, 7778716, 4110060, 2086331, 1047214,
    524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2};

  function automatic longint round_div_pow2(longint v, int s);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 << (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint line_angle_q24(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = lfvc_pkg::HALF_PI_Q24;
      end else begin
        t = x; x = -y; y = t; z = -lfvc_pkg::HALF_PI_Q24;
      end
    end
    for (int i = 0; i < 24; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_Q24[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_Q24[i];
      end
    end
    return z;
  endfunction

  function automatic command_t predict_commands(longint rx, longint ry, longint hd,
      longint sx, longint sy, longint ex, longint ey, longint want);
    command_t c;
    longint dx, dy, nx, ny, ux, uy, e, lat, lh, err, om, fl, v, lo, ddx, ddy;
    longint unsigned ax, ay, mx, len, end_dist, q, mv, mdx, mdy;
    c = '0;
    dx = ex - sx;
    dy = ey - sy;
    if (dx == 0 && dy == 0) begin
      c.degen = 1'b1;
      return c;
    end
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    mx = ax > ay ? ax : ay;
    while (mx >= (64'd1 << 31)) begin
      ax >>= 1; ay >>= 1; mx >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      ax <<= 1; ay <<= 1; mx <<= 1;
    end
    len = int_sqrt(ax * ax + ay * ay);
    nx = dx < 0 ? -longint'(ax) : longint'(ax);
    ny = dy < 0 ? -longint'(ay) : longint'(ay);
    ux = longint'(((ax << 28) + (len >> 1)) / len);
    uy = longint'(((ay << 28) + (len >> 1)) / len);
    if (dx < 0) ux = -ux;
    if (dy < 0) uy = -uy;
    e = round_div_pow2(ux * (ry - sy) - uy * (rx - sx), 28);
    lat = round_div_pow2(-(longint'(gain) * e), 12);
    lat = clip(lat, -longint'(lat_lim), longint'(lat_lim));
    lh = round_div_pow2(line_angle_q24(ny, nx), 12);
    err = lh - hd;
    while (err > lfvc_pkg::PI_Q12) err -= lfvc_pkg::TWO_PI_Q12;
    while (err <= -lfvc_pkg::PI_Q12) err += lfvc_pkg::TWO_PI_Q12;
    om = round_div_pow2(err * longint'(gain), 8);
    om = clip(om, -longint'(turn_lim), longint'(turn_lim));
    fl = longint'(fwd_lim);
    v = want < fl ? want : fl;
    ddx = ex - rx;
    ddy = ey - ry;
    mdx = ddx < 0 ? -ddx : ddx;
    mdy = ddy < 0 ? -ddy : ddy;
    if (slow_dist != 0 && mdx < (64'd1 << 31) && mdy < (64'd1 << 31)) begin
      end_dist = int_sqrt(mdx * mdx + mdy * mdy);
      if (end_dist < slow_dist) begin
        mv = v < 0 ? -v : v;
        q = (mv * end_dist) / slow_dist;
        v = v < 0 ? -longint'(q) : longint'(q);
      end
    end
    lo = rev_en ? -fl : 0;
    v = clip(v, lo, fl);
    c.fwd = v[15:0];
    c.lat = lat[15:0];
    c.turn = om[15:0];
    return c;
  endfunction

  assign pending_count = command_q.size();

  always @(posedge clk) begin
    command_t want_c, got;
    if (!rst_n) begin
      fwd_lim <= 15'd4096;
      lat_lim <= 15'd2048;
      turn_lim <= 15'd4096;
      slow_dist <= '0;
      gain <= 16'd256;
      rev_en <= 1'b0;
      command_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) begin
        case (lfvc_pkg::cfg_reg_t'(cfg_index))
          lfvc_pkg::CFG_FORWARD_LIMIT:     fwd_lim <= cfg_data[14:0];
          lfvc_pkg::CFG_LATERAL_LIMIT:     lat_lim <= cfg_data[14:0];
          lfvc_pkg::CFG_TURN_LIMIT:        turn_lim <= cfg_data[14:0];
          lfvc_pkg::CFG_SLOWDOWN_DISTANCE: slow_dist <= cfg_data;
          lfvc_pkg::CFG_STEER_GAIN:        gain <= cfg_data[15:0];
          lfvc_pkg::CFG_REVERSE_ALLOWED:   rev_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        got = '{out_forward_speed, out_lateral_speed, out_turn_rate, out_degenerate_line};
        if (command_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          want_c = command_q.pop_front();
          if (got !== want_c) begin
            fail_count <= fail_count + 1;
            if (got.fwd !== want_c.fwd)
              $error("forward_speed: expected %0d, got %0d", want_c.fwd, got.fwd);
            if (got.lat !== want_c.lat)
              $error("lateral_speed: expected %0d, got %0d", want_c.lat, got.lat);
            if (got.turn !== want_c.turn)
              $error("turn_rate: expected %0d, got %0d", want_c.turn, got.turn);
            if (got.degen !== want_c.degen)
              $error("degenerate_line: expected %0d, got %0d", want_c.degen, got.degen);
          end
        end
      end
      if (in_valid && !in_stall)
        command_q.push_back(predict_commands(in_robot_x, in_robot_y, in_robot_heading,
            in_start_x, in_start_y, in_end_x, in_end_y, in_wanted_speed));
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Testbench top: clock, reset, stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = 70;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic signed [31:0] in_robot_x = '0, in_robot_y = '0;
  logic signed [14:0] in_robot_heading = '0;
  logic signed [31:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic signed [15:0] in_wanted_speed = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [15:0] out_forward_speed, out_lateral_speed, out_turn_rate;
  logic out_degenerate_line;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  int fail_count, pending_count, result_count;
  int idle_cycles = 0;
  int sent = 0;
  bit calm = 1'b0;

  always #1 clk = ~clk;

  line_following_velocity_controller u_dut (.*);
  lfvc_checker u_checker (.*);

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall in bursts, none once calm
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(lfvc_pkg::cfg_reg_t idx, logic [30:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 4000000)) - 2000000;
      2: return $signed($urandom_range(0, 200000)) - 100000;
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic send_item(logic signed [31:0] rx, ry, logic signed [14:0] hd,
      logic signed [31:0] sx, sy, ex, ey, logic signed [15:0] ws);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_robot_x <= rx; in_robot_y <= ry; in_robot_heading <= hd;
    in_start_x <= sx; in_start_y <= sy; in_end_x <= ex; in_end_y <= ey;
    in_wanted_speed <= ws;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic finish_items;
    in_valid <= 1'b0;
    drain();
  endtask

  task automatic random_items(int n);
    logic signed [31:0] sx, sy;
    for (int i = 0; i < n; i++) begin
      sx = rand_pos();
      sy = rand_pos();
      if ($urandom_range(0, 19) == 0)
        send_item(rand_pos(), rand_pos(), 15'($urandom), sx, sy, sx, sy, 16'($urandom));
      else if ($urandom_range(0, 3) == 0)
        send_item(rand_pos(), rand_pos(), 15'($urandom), sx, sy, rand_pos(), rand_pos(),
                  16'($urandom));
      else
        send_item(sx + $signed($urandom_range(0, 600000)) - 300000,
                  sy + $signed($urandom_range(0, 600000)) - 300000,
                  15'($signed($urandom_range(0, 25736)) - 12868), sx, sy,
                  sx + $signed($urandom_range(0, 400000)) - 200000,
                  sy + $signed($urandom_range(0, 400000)) - 200000,
                  16'($urandom));
    end
    finish_items();
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: degenerate segment, extremes, wrapped heading, far end
    send_item(0, 0, 0, 32'sd5000, 32'sd5000, 32'sd5000, 32'sd5000, 16'sd1000);
    send_item(0, 0, 0, 0, 0, 1, 0, 16'sd4096);
    send_item(32'h7fffffff, 32'h80000000, 15'sd12868, 32'h80000000, 32'h80000000,
              32'h7fffffff, 32'h7fffffff, 16'sh7fff);
    send_item(32'h80000000, 32'h7fffffff, -15'sd12868, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h80000000, 16'sh8000);
    send_item(0, 32'sd65536, 15'sh3fff, 0, 0, -32'sd65536, 0, -16'sd4096);
    send_item(0, -32'sd65536, 15'sh4000, 0, 0, -32'sd65536, -32'sd3, 16'sd100);
    send_item(32'sd1000, 0, 15'sd0, 0, 0, 0, 32'sd65536, 16'sd4096);
    send_item(-32'sd1000, 0, 15'sd0, 0, 0, 0, -32'sd65536, 16'sd4096);
    send_item(32'sd1, 32'sd1, 15'sh7fff, 0, 0, 32'sd1, 32'sd1, 16'sd5000);
    send_item(0, 0, 0, 32'h7fffffff, 0, 32'h80000000, 0, 16'sd2000);
    send_item(32'h80000000, 0, 0, 0, 0, 32'h7fffffff, 32'sd65536, 16'sd2000);
    finish_items();

    write_reg(lfvc_pkg::CFG_SLOWDOWN_DISTANCE, 31'd200000);
    write_reg(lfvc_pkg::CFG_REVERSE_ALLOWED, 31'd1);
    write_reg(lfvc_pkg::CFG_STEER_GAIN, 31'd1024);
    write_reg(lfvc_pkg::CFG_LATERAL_LIMIT, 31'd32767);
    write_reg(lfvc_pkg::CFG_TURN_LIMIT, 31'd32767);
    write_reg(lfvc_pkg::CFG_FORWARD_LIMIT, 31'd32767);
    write_reg(lfvc_pkg::cfg_reg_t'(3'd7), 31'h7fffffff);
    send_item(0, 0, 0, 0, 0, 32'sd100000, 0, 16'sh8000);
    send_item(32'sd90000, 0, 0, 0, 0, 32'sd100000, 0, -16'sd3000);
    random_items(300);

    write_reg(lfvc_pkg::CFG_FORWARD_LIMIT, 31'd0);
    write_reg(lfvc_pkg::CFG_LATERAL_LIMIT, 31'd0);
    write_reg(lfvc_pkg::CFG_TURN_LIMIT, 31'd0);
    write_reg(lfvc_pkg::CFG_STEER_GAIN, 31'd65535);
    random_items(150);

    write_reg(lfvc_pkg::CFG_FORWARD_LIMIT, 31'($urandom_range(0, 32767)));
    write_reg(lfvc_pkg::CFG_LATERAL_LIMIT, 31'($urandom_range(0, 32767)));
    write_reg(lfvc_pkg::CFG_TURN_LIMIT, 31'($urandom_range(0, 32767)));
    write_reg(lfvc_pkg::CFG_SLOWDOWN_DISTANCE, 31'h7fffffff);
    write_reg(lfvc_pkg::CFG_STEER_GAIN, 31'd0);
    write_reg(lfvc_pkg::CFG_REVERSE_ALLOWED, 31'd0);
    random_items(300);

    write_reg(lfvc_pkg::CFG_SLOWDOWN_DISTANCE, 31'($urandom_range(1, 500000)));
    write_reg(lfvc_pkg::CFG_STEER_GAIN, 31'($urandom_range(0, 65535)));
    write_reg(lfvc_pkg::CFG_REVERSE_ALLOWED, 31'd1);
    random_items(300);

    calm = 1'b1;
    random_items(200);

    $display("Covered %0d input and %0d result transactions over five register settings,",
             sent, result_count);
    $display("including degenerate segments, extreme poses, zero limits and slowdown.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lfvc_pkg.sv
rtl/core/lfvc_isqrt.sv
rtl/core/lfvc_div.sv
rtl/core/line_following_velocity_controller.sv
sim/lfvc_checker.sv
sim/testbench.sv
